// ===== src/rgbf_pkg.sv =====
// Shared types and constants of the RGB 3x3 window filter.
package rgbf_pkg;

  // Width of the frame size registers and the limit applied to the row count.
  localparam int unsigned DIM_W        = 11;
  localparam int unsigned HEIGHT_LIMIT = 1024;

  // Pixel, channel and coefficient layout.
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned KROW_W = 3 * COEF_W;

  // Datapath widths: one tap product, the sum of one kernel row and the full sum.
  localparam int unsigned PROD_W = 24;
  localparam int unsigned ROWS_W = 26;
  localparam int unsigned SUM_W  = 28;

  // Configuration write port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = KROW_W;

  // Register reset values: 512 x 512 frame and a mean kernel of 455/4096 per tap.
  localparam logic [DIM_W-1:0]  FRAME_DIM_RESET = 11'd512;
  localparam logic [KROW_W-1:0] KERNEL_RESET    = 48'h01C7_01C7_01C7;

  // Depth of the result queue; it covers the pipeline latency at one pixel per clock.
  localparam int unsigned OUT_DEPTH = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_KERNEL_TOP   = 3'd2,
    CFG_KERNEL_MID   = 3'd3,
    CFG_KERNEL_BOT   = 3'd4
  } cfg_index_e;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_type_e;

  typedef logic [PIX_W-1:0] pixel_t;

  // Window indexed [row][column]; row 0 is the oldest line, column 0 the left one.
  typedef logic [2:0][2:0][PIX_W-1:0] window_t;

  typedef logic [2:0][KROW_W-1:0] kernel_t;

  // Per-result tap masks and end of frame flag.
  typedef struct packed {
    logic [2:0] row_ok;
    logic [2:0] col_ok;
    logic       frame_end;
  } tap_ctrl_t;

  typedef struct packed {
    logic            frame_end;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } result_t;

endpackage

// ===== src/rgbf_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module rgbf_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same entry is written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rgbf_scan.sv =====
// Raster position counters, frame bookkeeping and tap masks for each request.
module rgbf_scan import rgbf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [DIM_W-1:0]             frame_width_i,
  input  logic [DIM_W-1:0]             frame_height_i,
  input  logic                         accept_i,
  input  logic                         drain_i,
  output logic                         item_valid_o,
  output logic                         item_emit_o,
  output logic [$clog2(MAX_WIDTH)-1:0] item_col_o,
  output tap_ctrl_t                    item_ctrl_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W = (WD_W > DIM_W) ? WD_W : DIM_W;
  localparam int unsigned RW_W  = DIM_W + 1;
  localparam int unsigned TOT_W = WD_W + DIM_W;
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);

  logic [COL_W-1:0] col_q, col_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [WD_W-1:0]  wd;
  logic [DIM_W-1:0] ht;
  logic [TOT_W-1:0] total_full;
  logic [CNT_W-1:0] total;
  logic [COL_W-1:0] c1;
  logic [DIM_W-1:0] r1;
  logic [CNT_W-1:0] n1, n2;
  logic             restart, ignore, emit, frame_end;
  logic [RW_W-1:0]  row_base, rk;
  logic [WD_W:0]    cv, ck;
  logic [2:0]       row_ok, col_ok;

  always_comb begin
    // Effective frame size.
    if (frame_width_i == '0) begin
      wd = WD_W'(1);
    end else if (CMP_W'(frame_width_i) > CMP_W'(MAX_WIDTH)) begin
      wd = WD_W'(MAX_WIDTH);
    end else begin
      wd = WD_W'(frame_width_i);
    end
    if (frame_height_i == '0) begin
      ht = DIM_W'(1);
    end else if (frame_height_i > DIM_W'(HEIGHT_LIMIT)) begin
      ht = DIM_W'(HEIGHT_LIMIT);
    end else begin
      ht = frame_height_i;
    end
    total_full = wd * ht;
    total      = total_full[CNT_W-1:0];

    // Positions left over from a different frame size restart the row or frame.
    c1 = (WD_W'(col_q) >= wd) ? '0 : col_q;
    r1 = row_q;
    n1 = cnt_q;
    restart = (RW_W'(row_q) > (RW_W'(ht) + RW_W'(1))) || (cnt_q >= total);
    if (restart) begin
      c1 = '0;
      r1 = '0;
      n1 = '0;
    end

    // A drain with no pixel of the frame seen yet does nothing.
    ignore = drain_i && (r1 == '0) && (c1 == '0);
    emit   = (r1 >= DIM_W'(2)) || ((r1 == DIM_W'(1)) && (c1 != '0));

    // At column zero the result is the last pixel of the row two back;
    // otherwise it is the pixel one row up and one column left.
    row_base = (c1 == '0) ? RW_W'(3) : RW_W'(2);
    cv       = (c1 == '0) ? (WD_W + 1)'(wd) : (WD_W + 1)'(c1);
    for (int k = 0; k < 3; k++) begin
      rk        = RW_W'(r1) + RW_W'(k);
      row_ok[k] = (rk >= row_base) && (rk < (RW_W'(ht) + row_base));
      ck        = cv + (WD_W + 1)'(k);
      col_ok[k] = (ck >= (WD_W + 1)'(2)) && (ck < ((WD_W + 1)'(wd) + (WD_W + 1)'(2)));
    end

    // Advance the raster position.
    if ((WD_W'(c1) + WD_W'(1)) >= wd) begin
      col_d = '0;
      row_d = r1 + DIM_W'(1);
    end else begin
      col_d = c1 + COL_W'(1);
      row_d = r1;
    end
    n2        = n1 + CNT_W'(1);
    cnt_d     = n1;
    frame_end = 1'b0;
    if (emit) begin
      if (n2 >= total) begin
        frame_end = 1'b1;
        col_d     = '0;
        row_d     = '0;
        cnt_d     = '0;
      end else begin
        cnt_d = n2;
      end
    end
    if (ignore) begin
      col_d = c1;
      row_d = r1;
      cnt_d = n1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      cnt_q <= cnt_d;
    end
  end

  assign item_valid_o = accept_i && !ignore;
  assign item_emit_o  = emit;
  assign item_col_o   = c1;
  assign item_ctrl_o  = '{row_ok: row_ok, col_ok: col_ok, frame_end: frame_end};

endmodule

// ===== src/rgbf_line.sv =====
// Line store read-modify-write with forwarding and the 3x3 pixel window.
module rgbf_line import rgbf_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  logic                         item_emit_i,
  input  logic [$clog2(MAX_WIDTH)-1:0] item_col_i,
  input  pixel_t                       item_pix_i,
  input  tap_ctrl_t                    item_ctrl_i,
  output logic                         win_valid_o,
  output window_t                      win_o,
  output tap_ctrl_t                    win_ctrl_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  // Each RAM word holds the two older lines of one column: bits 23:0 the
  // top line, bits 47:24 the middle line.
  logic [2*PIX_W-1:0] rd_word;
  logic               s1_valid_q, s1_emit_q;
  logic [COL_W-1:0]   s1_addr_q;
  pixel_t             s1_pix_q;
  tap_ctrl_t          s1_ctrl_q;
  logic               fwd_d, fwd_q;
  pixel_t             fwd_top_q, fwd_mid_q;
  pixel_t             eff_top, eff_mid;
  window_t            win_q;
  logic               win_valid_q;
  tap_ctrl_t          win_ctrl_q;

  rgbf_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_pix_q, eff_mid}),
    .raddr_i (item_col_i),
    .rdata_o (rd_word)
  );

  // The column being written in this cycle is read by the next request when
  // both share a column; its data then comes from the forwarding registers.
  assign fwd_d   = item_valid_i && s1_valid_q && (s1_addr_q == item_col_i);
  assign eff_top = fwd_q ? fwd_top_q : rd_word[PIX_W-1:0];
  assign eff_mid = fwd_q ? fwd_mid_q : rd_word[2*PIX_W-1:PIX_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      win_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= item_valid_i;
      fwd_q       <= fwd_d;
      win_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_i) begin
      s1_emit_q <= item_emit_i;
      s1_addr_q <= item_col_i;
      s1_pix_q  <= item_pix_i;
      s1_ctrl_q <= item_ctrl_i;
    end
    if (fwd_d) begin
      fwd_top_q <= eff_mid;
      fwd_mid_q <= s1_pix_q;
    end
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= eff_top;
      win_q[1][2] <= eff_mid;
      win_q[2][2] <= s1_pix_q;
    end
    win_ctrl_q <= s1_ctrl_q;
  end

  assign win_valid_o = win_valid_q;
  assign win_o       = win_q;
  assign win_ctrl_o  = win_ctrl_q;

endmodule

// ===== src/rgbf_kernel.sv =====
// Masked tap products, adder tree, magnitude, scaling and saturation per channel.
module rgbf_kernel import rgbf_pkg::*; #(
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  window_t   win_i,
  input  tap_ctrl_t ctrl_i,
  input  kernel_t   kernel_i,
  output logic      res_valid_o,
  output result_t   res_o
);

  function automatic logic signed [PROD_W-1:0] tap_product(logic [COEF_W-1:0] coef,
                                                           logic [CH_W-1:0] samp);
    logic signed [COEF_W+CH_W:0] full;
    full = $signed(coef) * $signed({1'b0, samp});
    return full[PROD_W-1:0];
  endfunction

  logic signed [PROD_W-1:0] prod_q [3][3][3];
  logic signed [ROWS_W-1:0] rows_q [3][3];
  logic signed [SUM_W-1:0]  sum_q  [3];
  logic [2:0]               valid_q;
  logic [2:0]               end_q;
  logic [SUM_W-1:0]         mag    [3];
  logic [SUM_W-1:0]         scaled [3];
  logic [2:0][CH_W-1:0]     chan;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    end_q <= {end_q[1:0], ctrl_i.frame_end};
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[ch][r][c] <= (ctrl_i.row_ok[r] && ctrl_i.col_ok[c])
              ? tap_product(kernel_i[r][COEF_W*c +: COEF_W], win_i[r][c][CH_W*ch +: CH_W])
              : '0;
        end
        rows_q[ch][r] <= ROWS_W'(prod_q[ch][r][0]) + ROWS_W'(prod_q[ch][r][1])
                       + ROWS_W'(prod_q[ch][r][2]);
      end
      sum_q[ch] <= SUM_W'(rows_q[ch][0]) + SUM_W'(rows_q[ch][1]) + SUM_W'(rows_q[ch][2]);
    end
  end

  // Magnitude, truncation of the fraction bits, clamp to the channel range.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      mag[ch]    = sum_q[ch][SUM_W-1] ? SUM_W'(-sum_q[ch]) : SUM_W'(sum_q[ch]);
      scaled[ch] = mag[ch] >> COEF_FRAC_BITS;
      chan[ch]   = (scaled[ch] > SUM_W'({CH_W{1'b1}})) ? {CH_W{1'b1}} : scaled[ch][CH_W-1:0];
    end
  end

  assign res_valid_o = valid_q[2];
  assign res_o       = {end_q[2], chan[2], chan[1], chan[0]};

endmodule

// ===== src/rgbf_fifo.sv =====
// Result queue with slot reservation for every result still in the pipeline.
module rgbf_fifo import rgbf_pkg::*; #(
  parameter int unsigned DEPTH = 8
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    reserve_i,
  input  logic    push_i,
  input  result_t push_data_i,
  input  logic    pop_i,
  output logic    has_room_o,
  output logic    out_valid_o,
  output result_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t          mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q, resv_q;

  // A slot is held from the accepted request until its result leaves the
  // queue, so a push never finds the queue full.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      resv_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
      resv_q  <= resv_q + CNT_W'(reserve_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign has_room_o  = resv_q < CNT_W'(DEPTH);
  assign out_valid_o = count_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];

endmodule

// ===== src/rgb_3x3_window_filter_top.sv =====
// Top level of the RGB 3x3 window filter with zero padding at the frame edges.
//
//  Channel   Direction  Handshake              Payload
//  --------  ---------  ---------------------  -------------------------------------------
//  s_axis    in         tvalid / tready        tdata: red, green, blue; tuser: req_type
//  m_axis    out        tvalid / tready        tdata: red, green, blue; tlast: frame_end
//  cfg       in         cfg_we_i (no wait)     cfg_index_i selects register, cfg_data_i
//
// The filter takes one request per clock as long as the result queue has room; the
// line RAM does one read and one write per cycle, which sets that figure.
// A request's result goes through the line store, window and kernel registers into the result queue.
// Reset clears the counters, the pipeline and the result queue at once; the line
// RAM is not cleared, since every entry is written before it feeds a tap in the frame.
// A stalled m_axis fills the eight-entry result queue; s_axis_tready drops only
// when eight results are queued or still in the pipeline.
module rgb_3x3_window_filter_top import rgbf_pkg::*; #(
  parameter int unsigned MAX_WIDTH      = 1024,
  parameter int unsigned COEF_FRAC_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Pixel requests.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // red_in [7:0], green_in [15:8], blue_in [23:16]
  input  logic [0:0]            s_axis_tuser,  // req_type [0]
  // Filtered pixels.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata,  // red_out [7:0], green_out [15:8], blue_out [23:16]
  output logic                  m_axis_tlast,
  // Register writes.
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);

  logic [DIM_W-1:0] frame_width_q, frame_height_q;
  kernel_t          kernel_q;

  logic             accept;
  logic             drain;
  pixel_t           item_pix;
  logic             item_valid, item_emit;
  logic [COL_W-1:0] item_col;
  tap_ctrl_t        item_ctrl;
  logic             win_valid;
  window_t          win;
  tap_ctrl_t        win_ctrl;
  logic             res_valid;
  result_t          res;
  result_t          out_data;

  // Register file. Writes to an index past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_DIM_RESET;
      frame_height_q <= FRAME_DIM_RESET;
      kernel_q       <= {KERNEL_RESET, KERNEL_RESET, KERNEL_RESET};
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_KERNEL_TOP:   kernel_q[0]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_MID:   kernel_q[1]    <= cfg_data_i[KROW_W-1:0];
        CFG_KERNEL_BOT:   kernel_q[2]    <= cfg_data_i[KROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign drain    = req_type_e'(s_axis_tuser[0]) == REQ_DRAIN;
  // A drain request moves a zero pixel through the line store and window.
  assign item_pix = drain ? '0 : s_axis_tdata[PIX_W-1:0];

  rgbf_scan #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .accept_i       (accept),
    .drain_i        (drain),
    .item_valid_o   (item_valid),
    .item_emit_o    (item_emit),
    .item_col_o     (item_col),
    .item_ctrl_o    (item_ctrl)
  );

  rgbf_line #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_emit_i  (item_emit),
    .item_col_i   (item_col),
    .item_pix_i   (item_pix),
    .item_ctrl_i  (item_ctrl),
    .win_valid_o  (win_valid),
    .win_o        (win),
    .win_ctrl_o   (win_ctrl)
  );

  rgbf_kernel #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_kernel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (win_valid),
    .win_i       (win),
    .ctrl_i      (win_ctrl),
    .kernel_i    (kernel_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rgbf_fifo #(
    .DEPTH (OUT_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (item_valid && item_emit),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tvalid && m_axis_tready),
    .has_room_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data)
  );

  assign m_axis_tdata = {out_data.blue, out_data.green, out_data.red};
  assign m_axis_tlast = out_data.frame_end;

endmodule

// ===== src/rgbf_checker.sv =====
// Port-level assertions of the RGB 3x3 window filter and their bind to the top level.
module rgbf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A held result keeps its data until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // Requests are held back only while results wait at the output.
  a_ready_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // The pipeline has a fixed depth: a result into an empty queue comes from the request
  // that has passed through the line store, window, kernel and queue registers.
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 6))
    else $error("result without a matching request");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result shown right after reset");

endmodule

bind rgb_3x3_window_filter_top rgbf_checker u_rgbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
